/* rtl/core/utf8ts_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8ts_pkg
// Shared widths, UTF-8 byte classes, event type and counter helpers for the
// UTF-8 text statistics block.
// ----------------------------------------------------------------------------
package utf8ts_pkg;

    // width of every internal total
    localparam int COUNT_WIDTH = 32;
    // width of the reported fields
    localparam int OUT_WIDTH   = 32;

    typedef logic [COUNT_WIDTH-1:0] cnt_t;
    typedef logic [20:0]            code_t;

    // byte classes
    localparam logic [7:0] LEAD2_LO   = 8'hc2;
    localparam logic [7:0] LEAD2_HI   = 8'hdf;
    localparam logic [7:0] LEAD3_LO   = 8'he0;
    localparam logic [7:0] LEAD3_HI   = 8'hef;
    localparam logic [7:0] LEAD4_LO   = 8'hf0;
    localparam logic [7:0] LEAD4_HI   = 8'hf4;
    localparam logic [7:0] ASCII_LIM  = 8'h80;

    // code points of interest
    localparam code_t CP_NULL      = 21'h000000;
    localparam code_t CP_QUESTION  = 21'h00003f;
    localparam code_t CP_REPL      = 21'h00fffd;
    localparam code_t CP_MAX       = 21'h10ffff;
    localparam code_t CP_SURR_LO   = 21'h00d800;
    localparam code_t CP_SURR_HI   = 21'h00dfff;
    localparam code_t CP_MIN3      = 21'h000800;
    localparam code_t CP_MIN4      = 21'h010000;

    // Hangul ranges
    localparam code_t HG_JAMO_LO   = 21'h001100;
    localparam code_t HG_JAMO_HI   = 21'h0011ff;
    localparam code_t HG_COMPAT_LO = 21'h003130;
    localparam code_t HG_COMPAT_HI = 21'h00318f;
    localparam code_t HG_EXTA_LO   = 21'h00a960;
    localparam code_t HG_EXTA_HI   = 21'h00a97f;
    localparam code_t HG_SYL_LO    = 21'h00ac00;
    localparam code_t HG_SYL_HI    = 21'h00d7a3;
    localparam code_t HG_EXTB_LO   = 21'h00d7b0;
    localparam code_t HG_EXTB_HI   = 21'h00d7ff;

    // per-item counting events from the decoder
    typedef struct packed {
        logic       last;
        logic       hangul;
        logic       question;
        logic       zero_byte;
        logic [2:0] repl;
    } utf8ts_event_t;

    // saturating add of two totals
    function automatic cnt_t sat_add(cnt_t a, cnt_t b);
        logic [COUNT_WIDTH:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : s[COUNT_WIDTH-1:0];
    endfunction

    // low bits of a total for the result fields
    function automatic logic [OUT_WIDTH-1:0] to_out(cnt_t v);
        logic [63:0] w;
        w = 64'(v);
        return w[OUT_WIDTH-1:0];
    endfunction

endpackage

/* rtl/core/utf8ts_decode.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8ts_decode
// Strict UTF-8 decoder step: keeps the open sequence and turns one item into
// counting events (Hangul, question mark, null, replacement count).
// ----------------------------------------------------------------------------
module utf8ts_decode
    import utf8ts_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  logic [7:0]    text_byte,
    input  logic          has_byte,
    input  logic          end_of_text,
    output utf8ts_event_t ev
);

    logic [1:0] needed_reg, needed_next;
    logic [1:0] collected_reg, collected_next;
    code_t      partial_reg, partial_next;

    logic       do_lead;
    logic       point_valid;
    code_t      point;
    code_t      joined;
    logic [1:0] coll_inc;
    logic       bad;
    logic [2:0] repl_break;
    logic [2:0] repl_reject;
    logic [2:0] repl_flush;
    logic       hangul_hit;

    // next sequence state and the single decoded point of this item
    always_comb
    begin
        needed_next    = needed_reg;
        collected_next = collected_reg;
        partial_next   = partial_reg;
        do_lead        = 1'b0;
        point_valid    = 1'b0;
        point          = CP_NULL;
        repl_break     = 3'd0;
        repl_reject    = 3'd0;
        repl_flush     = 3'd0;
        joined         = {partial_reg[14:0], text_byte[5:0]};
        coll_inc       = collected_reg + 2'd1;
        bad            = 1'b0;

        if (has_byte)
        begin
            if (needed_reg == 2'd0)
            begin
                do_lead = 1'b1;
            end
            else if (text_byte[7:6] != 2'b10)
            begin
                // broken sequence: lead and continuations so far are replaced
                repl_break     = 3'({1'b0, collected_reg}) + 3'd1;
                needed_next    = 2'd0;
                collected_next = 2'd0;
                partial_next   = CP_NULL;
                do_lead        = 1'b1;
            end
            else
            begin
                partial_next   = joined;
                collected_next = coll_inc;
                if (coll_inc == needed_reg)
                begin
                    bad = (needed_reg == 2'd2 && joined < CP_MIN3) ||
                          (needed_reg == 2'd3 && joined < CP_MIN4) ||
                          (joined >= CP_SURR_LO && joined <= CP_SURR_HI) ||
                          (joined > CP_MAX);
                    if (bad)
                    begin
                        repl_reject = 3'({1'b0, needed_reg}) + 3'd1;
                    end
                    else
                    begin
                        point_valid = 1'b1;
                        point       = joined;
                    end
                    needed_next    = 2'd0;
                    collected_next = 2'd0;
                    partial_next   = CP_NULL;
                end
            end

            // lead byte classification
            if (do_lead)
            begin
                if (text_byte < ASCII_LIM)
                begin
                    point_valid = 1'b1;
                    point       = 21'(text_byte);
                end
                else if (text_byte >= LEAD2_LO && text_byte <= LEAD2_HI)
                begin
                    partial_next   = 21'(text_byte[4:0]);
                    needed_next    = 2'd1;
                    collected_next = 2'd0;
                end
                else if (text_byte >= LEAD3_LO && text_byte <= LEAD3_HI)
                begin
                    partial_next   = 21'(text_byte[3:0]);
                    needed_next    = 2'd2;
                    collected_next = 2'd0;
                end
                else if (text_byte >= LEAD4_LO && text_byte <= LEAD4_HI)
                begin
                    partial_next   = 21'(text_byte[2:0]);
                    needed_next    = 2'd3;
                    collected_next = 2'd0;
                end
                else
                begin
                    point_valid = 1'b1;
                    point       = CP_REPL;
                end
            end
        end

        // flush a sequence still open at end of text
        if (end_of_text && needed_next != 2'd0)
        begin
            repl_flush     = 3'({1'b0, collected_next}) + 3'd1;
            needed_next    = 2'd0;
            collected_next = 2'd0;
            partial_next   = CP_NULL;
        end
    end

    // point classification
    always_comb
    begin
        hangul_hit = (point >= HG_JAMO_LO   && point <= HG_JAMO_HI)   ||
                     (point >= HG_COMPAT_LO && point <= HG_COMPAT_HI) ||
                     (point >= HG_EXTA_LO   && point <= HG_EXTA_HI)   ||
                     (point >= HG_SYL_LO    && point <= HG_SYL_HI)    ||
                     (point >= HG_EXTB_LO   && point <= HG_EXTB_HI);
        ev.last      = end_of_text;
        ev.hangul    = point_valid && hangul_hit;
        ev.question  = point_valid && (point == CP_QUESTION);
        ev.zero_byte = point_valid && (point == CP_NULL);
        ev.repl      = repl_break + repl_reject + repl_flush +
                       3'(point_valid && (point == CP_REPL));
    end

    // sequence state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            needed_reg    <= 2'd0;
            collected_reg <= 2'd0;
            partial_reg   <= CP_NULL;
        end
        else if (step)
        begin
            needed_reg    <= needed_next;
            collected_reg <= collected_next;
            partial_reg   <= partial_next;
        end
    end

    // no open sequence keeps a collected count
    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (needed_reg == 2'd0) |-> (collected_reg == 2'd0))
        else $error("collected count without an open sequence");

    // an open sequence is never already complete
    a_open_short: assert property (@(posedge clk) disable iff (!rst_n)
        (needed_reg != 2'd0) |-> (collected_reg < needed_reg))
        else $error("open sequence holds all its bytes");

    // end of text always closes the sequence
    a_end_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (step && end_of_text) |=> (needed_reg == 2'd0))
        else $error("sequence left open across end of text");

    // replacement count of one item stays within four
    a_repl_bound: assert property (@(posedge clk) disable iff (!rst_n)
        step |-> (ev.repl <= 3'd4))
        else $error("replacement count out of range");

endmodule

/* rtl/core/utf8ts_stats.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8ts_stats
// Saturating totals and the result register loaded at each end of text.
// ----------------------------------------------------------------------------
module utf8ts_stats
    import utf8ts_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  utf8ts_event_t        ev,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [OUT_WIDTH-1:0] text_entities,
    output logic [OUT_WIDTH-1:0] hangul_text_entities,
    output logic [OUT_WIDTH-1:0] hangul_chars,
    output logic [OUT_WIDTH-1:0] qmark_chars,
    output logic [OUT_WIDTH-1:0] replacement_chars,
    output logic [OUT_WIDTH-1:0] null_chars,
    output logic [OUT_WIDTH-1:0] entity_hangul_chars
);

    cnt_t cur_hangul_reg, cur_hangul_next;
    cnt_t entity_reg, entity_next;
    cnt_t hg_entity_reg, hg_entity_next;
    cnt_t hg_char_reg, hg_char_next;
    cnt_t question_reg, question_next;
    cnt_t repl_reg, repl_next;
    cnt_t null_reg, null_next;
    cnt_t ent_h;
    logic out_valid_reg, out_valid_next;

    logic [OUT_WIDTH-1:0] r_entity_reg, r_hg_entity_reg, r_hg_char_reg;
    logic [OUT_WIDTH-1:0] r_question_reg, r_repl_reg, r_null_reg, r_ent_h_reg;

    // total updates for one item
    always_comb
    begin
        ent_h           = sat_add(cur_hangul_reg, COUNT_WIDTH'(ev.hangul));
        question_next   = sat_add(question_reg, COUNT_WIDTH'(ev.question));
        null_next       = sat_add(null_reg, COUNT_WIDTH'(ev.zero_byte));
        repl_next       = sat_add(repl_reg, COUNT_WIDTH'(ev.repl));
        entity_next     = entity_reg;
        hg_entity_next  = hg_entity_reg;
        hg_char_next    = hg_char_reg;
        cur_hangul_next = ent_h;
        if (ev.last)
        begin
            entity_next     = sat_add(entity_reg, COUNT_WIDTH'(1));
            cur_hangul_next = '0;
            if (ent_h != '0)
            begin
                hg_entity_next = sat_add(hg_entity_reg, COUNT_WIDTH'(1));
                hg_char_next   = sat_add(hg_char_reg, ent_h);
            end
        end
    end

    // result slot occupancy
    always_comb
    begin
        if (step && ev.last)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // totals and control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_hangul_reg <= '0;
            entity_reg     <= '0;
            hg_entity_reg  <= '0;
            hg_char_reg    <= '0;
            question_reg   <= '0;
            repl_reg       <= '0;
            null_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (step)
            begin
                cur_hangul_reg <= cur_hangul_next;
                entity_reg     <= entity_next;
                hg_entity_reg  <= hg_entity_next;
                hg_char_reg    <= hg_char_next;
                question_reg   <= question_next;
                repl_reg       <= repl_next;
                null_reg       <= null_next;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (step && ev.last)
        begin
            r_entity_reg    <= to_out(entity_next);
            r_hg_entity_reg <= to_out(hg_entity_next);
            r_hg_char_reg   <= to_out(hg_char_next);
            r_question_reg  <= to_out(question_next);
            r_repl_reg      <= to_out(repl_next);
            r_null_reg      <= to_out(null_next);
            r_ent_h_reg     <= to_out(ent_h);
        end
    end

    assign out_valid            = out_valid_reg;
    assign text_entities        = r_entity_reg;
    assign hangul_text_entities = r_hg_entity_reg;
    assign hangul_chars         = r_hg_char_reg;
    assign qmark_chars          = r_question_reg;
    assign replacement_chars    = r_repl_reg;
    assign null_chars           = r_null_reg;
    assign entity_hangul_chars  = r_ent_h_reg;

    // a finished text never overwrites a result not yet taken
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (step && ev.last) |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before transfer");

    // entity total moves only on end of text
    a_entity_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(step && ev.last) |=> $stable(entity_reg))
        else $error("entity total changed without end of text");

endmodule

/* rtl/core/utf8_text_statistics.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_text_statistics
// Strict UTF-8 decoder with saturating text statistics, reported per string.
//
//   channel | handshake            | payload
//   --------+----------------------+---------------------------------------
//   in      | in_valid / in_ready  | text_byte, has_byte, end_of_text
//   out     | out_valid / out_ready| seven 32-bit totals, one per string end
//
// One item per cycle sustained, except while an ending item is held; a result
// is loaded into the result register once the item that ends a string has
// passed the input register. The decode step and the total updates are
// combinational from the input register, so items follow back to back.
// Reset clears the open sequence, all totals and both valid flags.
// An item ending a string waits in the input register while an untaken
// result blocks the result register; other items keep flowing.
// ----------------------------------------------------------------------------
module utf8_text_statistics
    import utf8ts_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           text_byte,
    input  logic                 has_byte,
    input  logic                 end_of_text,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [OUT_WIDTH-1:0] text_entities,
    output logic [OUT_WIDTH-1:0] hangul_text_entities,
    output logic [OUT_WIDTH-1:0] hangul_chars,
    output logic [OUT_WIDTH-1:0] qmark_chars,
    output logic [OUT_WIDTH-1:0] replacement_chars,
    output logic [OUT_WIDTH-1:0] null_chars,
    output logic [OUT_WIDTH-1:0] entity_hangul_chars
);

    logic          item_valid_reg, item_valid_next;
    logic [7:0]    byte_reg;
    logic          has_reg;
    logic          last_reg;
    logic          step;
    utf8ts_event_t ev;

    // item in the input register moves on unless it ends a string and the result slot is blocked
    assign step     = item_valid_reg && (!last_reg || !out_valid || out_ready);
    assign in_ready = !item_valid_reg || step;

    always_comb
    begin
        if (in_valid && in_ready)
            item_valid_next = 1'b1;
        else if (step)
            item_valid_next = 1'b0;
        else
            item_valid_next = item_valid_reg;
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else
            item_valid_reg <= item_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= text_byte;
            has_reg  <= has_byte;
            last_reg <= end_of_text;
        end
    end

    // decode step
    utf8ts_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .text_byte   (byte_reg),
        .has_byte    (has_reg),
        .end_of_text (last_reg),
        .ev          (ev)
    );

    // totals and result register
    utf8ts_stats u_stats (
        .clk                  (clk),
        .rst_n                (rst_n),
        .step                 (step),
        .ev                   (ev),
        .out_ready            (out_ready),
        .out_valid            (out_valid),
        .text_entities        (text_entities),
        .hangul_text_entities (hangul_text_entities),
        .hangul_chars         (hangul_chars),
        .qmark_chars          (qmark_chars),
        .replacement_chars    (replacement_chars),
        .null_chars           (null_chars),
        .entity_hangul_chars  (entity_hangul_chars)
    );

endmodule
